// File: src/hbt_pkg.sv
package hbt_pkg;

    // Timer width; both millisecond timers saturate at all ones
    localparam int TIMER_BITS = 14;
    localparam int MS_W       = 14;
    localparam int CMP_W      = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef logic [TIMER_BITS-1:0] timer_t;
    localparam timer_t TIMER_MAX = {TIMER_BITS{1'b1}};

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_IDLE = 2'd1,
        MODE_HEAT = 2'd2,
        MODE_ERR  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        FUNC_TICK   = 3'd0,
        FUNC_SAMPLE = 3'd1,
        FUNC_PLUS   = 3'd2,
        FUNC_MINUS  = 3'd3,
        FUNC_TOGGLE = 3'd4
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_MIN     = 3'd0,
        CFG_SET_MAX     = 3'd1,
        CFG_HYSTERESIS  = 3'd2,
        CFG_DEBOUNCE_MS = 3'd3,
        CFG_BLINK_MS    = 3'd4,
        CFG_FAULT_VALUE = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [6:0]        set_min;
        logic [6:0]        set_max;
        logic [7:0]        hysteresis;
        logic [MS_W-1:0]   debounce_ms;
        logic [MS_W-1:0]   blink_ms;
        logic signed [11:0] fault_value;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [11:0] sample;
    } item_t;

    typedef struct packed {
        logic       heater_on;
        logic       red_led;
        logic       green_led;
        logic [1:0] mode;
        logic [6:0] setpoint;
    } res_t;

endpackage

// File: src/hbt_in_if.sv
interface hbt_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [11:0] sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink   (input valid, input func, input sample, output ready);
endinterface

// File: src/hbt_out_if.sv
interface hbt_out_if;
    logic       valid;
    logic       ready;
    logic       heater_on;
    logic       red_led;
    logic       green_led;
    logic [1:0] mode;
    logic [6:0] setpoint;

    modport source (output valid, output heater_on, output red_led, output green_led,
                    output mode, output setpoint, input ready);
    modport sink   (input valid, input heater_on, input red_led, input green_led,
                    input mode, input setpoint, output ready);
endinterface

// File: src/hbt_cfg_regs.sv
module hbt_cfg_regs
    import hbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write onto its register; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SET_MIN:     cfg_next.set_min     = cfg_data[6:0];
                CFG_SET_MAX:     cfg_next.set_max     = cfg_data[6:0];
                CFG_HYSTERESIS:  cfg_next.hysteresis  = cfg_data[7:0];
                CFG_DEBOUNCE_MS: cfg_next.debounce_ms = cfg_data[MS_W-1:0];
                CFG_BLINK_MS:    cfg_next.blink_ms    = cfg_data[MS_W-1:0];
                CFG_FAULT_VALUE: cfg_next.fault_value = signed'(cfg_data[11:0]);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_min     <= 7'd20;
            cfg_reg.set_max     <= 7'd70;
            cfg_reg.hysteresis  <= 8'd8;
            cfg_reg.debounce_ms <= MS_W'(400);
            cfg_reg.blink_ms    <= MS_W'(200);
            cfg_reg.fault_value <= 12'sd1360;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/hbt_ctrl.sv
module hbt_ctrl
    import hbt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step_en,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    mode_t              mode_reg, mode_next;
    logic [6:0]         setpoint_reg, setpoint_next;
    logic signed [11:0] temp_reg, temp_next;
    timer_t             since_toggle_reg, since_toggle_next;
    timer_t             since_blink_reg, since_blink_next;
    logic               red_level_reg, red_level_next;

    logic signed [8:0]  sp;
    logic signed [13:0] target;
    logic signed [13:0] low_th;
    logic signed [13:0] high_th;
    logic signed [13:0] temp_x;
    logic               red_out;

    // One event: timers, command, fault, clamp, hysteresis, blink
    always_comb
    begin
        mode_next         = mode_reg;
        temp_next         = temp_reg;
        since_toggle_next = since_toggle_reg;
        since_blink_next  = since_blink_reg;
        sp                = signed'({2'b00, setpoint_reg});

        case (func_t'(item.func))
            FUNC_TICK:
            begin
                if (since_toggle_reg != TIMER_MAX)
                    since_toggle_next = since_toggle_reg + timer_t'(1);
                if (since_blink_reg != TIMER_MAX)
                    since_blink_next = since_blink_reg + timer_t'(1);
            end
            FUNC_SAMPLE: temp_next = item.sample;
            FUNC_PLUS:   sp = sp + 9'sd1;
            FUNC_MINUS:  sp = sp - 9'sd1;
            FUNC_TOGGLE:
            begin
                if (CMP_W'(since_toggle_reg) > CMP_W'(cfg.debounce_ms))
                begin
                    mode_next         = (mode_reg == MODE_OFF) ? MODE_IDLE : MODE_OFF;
                    since_toggle_next = '0;
                end
            end
            default: ;
        endcase

        // Sensor fault overrides everything, off included
        if (temp_next == cfg.fault_value)
            mode_next = MODE_ERR;

        // Raise to the minimum first, so the maximum wins on a crossed pair
        if (sp < signed'({2'b00, cfg.set_min}))
            sp = signed'({2'b00, cfg.set_min});
        if (sp > signed'({2'b00, cfg.set_max}))
            sp = signed'({2'b00, cfg.set_max});
        setpoint_next = sp[6:0];

        // Hysteresis band around the set point, in sixteenths
        target  = signed'({3'b000, setpoint_next, 4'b0000});
        low_th  = target - signed'({6'b000000, cfg.hysteresis});
        high_th = target + signed'({6'b000000, cfg.hysteresis});
        temp_x  = 14'(temp_next);
        if (mode_next == MODE_IDLE)
        begin
            if (temp_x <= low_th)
                mode_next = MODE_HEAT;
        end
        else if (mode_next == MODE_HEAT)
        begin
            if (temp_x >= high_th)
                mode_next = MODE_IDLE;
        end

        // Red LED: blink in error, otherwise track the heater
        red_level_next = red_level_reg;
        if (mode_next == MODE_ERR)
        begin
            if (CMP_W'(since_blink_next) >= CMP_W'(cfg.blink_ms))
            begin
                red_level_next   = ~red_level_reg;
                since_blink_next = '0;
            end
            red_out = red_level_next;
        end
        else
        begin
            red_out        = (mode_next == MODE_HEAT);
            red_level_next = red_out;
        end

        res.heater_on = (mode_next == MODE_HEAT);
        res.red_led   = red_out;
        res.green_led = (mode_next != MODE_OFF);
        res.mode      = mode_next;
        res.setpoint  = setpoint_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_OFF;
            setpoint_reg     <= 7'd20;
            temp_reg         <= '0;
            since_toggle_reg <= '0;
            since_blink_reg  <= '0;
            red_level_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg         <= mode_next;
            setpoint_reg     <= setpoint_next;
            temp_reg         <= temp_next;
            since_toggle_reg <= since_toggle_next;
            since_blink_reg  <= since_blink_next;
            red_level_reg    <= red_level_next;
        end
    end

endmodule

// File: src/hysteresis_boiler_thermostat_core.sv
// Boiler thermostat with off, idle, heating and error modes. Each input beat is
// one event (millisecond tick, temperature sample, plus, minus or on/off) and
// gives exactly one result beat carrying heater, LED levels, mode and the
// clamped set point. One beat is taken every clock cycle unless the sink stalls
// with the input register full; a result passes through the input register and
// then the single-pass update logic into the result register. The result register
// holds a beat while the sink stalls and the input register can still take one
// more beat meanwhile. Configuration writes take effect on the next cycle and
// belong to idle periods only.
module hysteresis_boiler_thermostat_core
    import hbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    hbt_in_if.sink                in_ch,
    hbt_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;
    item_t item_reg;
    logic  in_valid_reg;
    res_t  res_next;
    res_t  res_reg;
    logic  out_valid_reg;
    logic  advance;

    hbt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A held beat moves on when the result register is free or draining
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.func   <= in_ch.func;
            item_reg.sample <= in_ch.sample;
        end
    end

    hbt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.heater_on = res_reg.heater_on;
    assign out_ch.red_led   = res_reg.red_led;
    assign out_ch.green_led = res_reg.green_led;
    assign out_ch.mode      = res_reg.mode;
    assign out_ch.setpoint  = res_reg.setpoint;

endmodule

// File: dv/hysteresis_boiler_thermostat_core_tb.sv
`timescale 1ns / 100ps

module hysteresis_boiler_thermostat_core_tb;
    import hbt_pkg::*;

    localparam int          TMR_TOP     = (1 << TIMER_BITS) - 1;
    localparam logic [2:0]  FUNC_SPARE5 = 3'd5;
    localparam logic [2:0]  FUNC_SPARE6 = 3'd6;
    localparam logic [2:0]  FUNC_SPARE7 = 3'd7;
    localparam int          SAMPLE_LO   = -880;
    localparam int          SAMPLE_HI   = 2000;
    localparam int          PHASE_BEATS = 182;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hbt_in_if  in_ch ();
    hbt_out_if out_ch ();

    hysteresis_boiler_thermostat_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Directed rows; want is only meaningful where fixed is set
    typedef struct {
        logic [2:0]         func;
        logic signed [11:0] sample;
        bit                 fixed;
        res_t               want;
    } dir_row_t;

    dir_row_t dir_tab [0:15] = '{
        '{FUNC_TICK,   12'sd0,     1'b1, '{1'b0, 1'b0, 1'b0, MODE_OFF, 7'd20}},
        '{FUNC_MINUS,  12'sd0,     1'b1, '{1'b0, 1'b0, 1'b0, MODE_OFF, 7'd20}},
        '{FUNC_PLUS,   12'sd0,     1'b1, '{1'b0, 1'b0, 1'b0, MODE_OFF, 7'd21}},
        '{FUNC_PLUS,   12'sd2000,  1'b0, '0},
        '{FUNC_SAMPLE, 12'sd2000,  1'b0, '0},
        '{FUNC_SAMPLE, -12'sd880,  1'b0, '0},
        '{FUNC_TOGGLE, -12'sd1,    1'b1, '{1'b0, 1'b0, 1'b0, MODE_OFF, 7'd22}},
        '{FUNC_SPARE5, 12'sd1365,  1'b0, '0},
        '{FUNC_SPARE6, -12'sd880,  1'b0, '0},
        '{FUNC_SPARE7, 12'sd0,     1'b0, '0},
        '{FUNC_SAMPLE, 12'sd1360,  1'b1, '{1'b0, 1'b0, 1'b1, MODE_ERR, 7'd22}},
        '{FUNC_TOGGLE, 12'sd0,     1'b1, '{1'b0, 1'b0, 1'b1, MODE_ERR, 7'd22}},
        '{FUNC_SAMPLE, 12'sd0,     1'b0, '0},
        '{FUNC_TICK,   12'sd0,     1'b0, '0},
        '{FUNC_MINUS,  12'sd0,     1'b0, '0},
        '{FUNC_SAMPLE, -12'sd1,    1'b0, '0}
    };

    // Thermostat shadow state and register copy
    cfg_t               cfg_shadow;
    mode_t              st_mode;
    logic [6:0]         st_setpoint;
    logic signed [11:0] st_temp;
    int                 st_since_toggle;
    int                 st_since_blink;
    logic               st_red;

    res_t pending_status [$];
    int   mismatches;
    int   src_idle_pct;
    int   snk_idle_pct;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Overall time limit
    initial
    begin
        #(64'd20_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic flag_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic int ms_bump(int t);
        return (t < TMR_TOP) ? t + 1 : TMR_TOP;
    endfunction

    // One event through the thermostat: timers, command, fault, clamp,
    // hysteresis switch, blink and outputs, in that order
    function automatic res_t thermostat_step(logic [2:0] f, logic signed [11:0] s);
        int   sp;
        int   smin;
        int   smax;
        int   hyst;
        int   temp;
        int   target;
        logic red_out;
        res_t r;
        sp   = st_setpoint;
        smin = cfg_shadow.set_min;
        smax = cfg_shadow.set_max;
        hyst = cfg_shadow.hysteresis;
        case (f)
            FUNC_TICK:
            begin
                st_since_toggle = ms_bump(st_since_toggle);
                st_since_blink  = ms_bump(st_since_blink);
            end
            FUNC_SAMPLE: st_temp = s;
            FUNC_PLUS:   sp = sp + 1;
            FUNC_MINUS:  sp = sp - 1;
            FUNC_TOGGLE:
            begin
                if (st_since_toggle > int'(cfg_shadow.debounce_ms))
                begin
                    st_mode         = (st_mode == MODE_OFF) ? MODE_IDLE : MODE_OFF;
                    st_since_toggle = 0;
                end
            end
            default: ;
        endcase

        temp = st_temp;
        if (st_temp == cfg_shadow.fault_value)
            st_mode = MODE_ERR;

        // set_max has the last word when the limits cross
        if (sp < smin)
            sp = smin;
        if (sp > smax)
            sp = smax;
        st_setpoint = sp[6:0];

        target = int'(st_setpoint) * 16;
        if (st_mode == MODE_IDLE)
        begin
            if (temp <= target - hyst)
                st_mode = MODE_HEAT;
        end
        else if (st_mode == MODE_HEAT)
        begin
            if (temp >= target + hyst)
                st_mode = MODE_IDLE;
        end

        if (st_mode == MODE_ERR)
        begin
            if (st_since_blink >= int'(cfg_shadow.blink_ms))
            begin
                st_red         = ~st_red;
                st_since_blink = 0;
            end
            red_out = st_red;
        end
        else
        begin
            red_out = (st_mode == MODE_HEAT);
            st_red  = red_out;
        end

        r.heater_on = (st_mode == MODE_HEAT);
        r.red_led   = red_out;
        r.green_led = (st_mode != MODE_OFF);
        r.mode      = st_mode;
        r.setpoint  = st_setpoint;
        return r;
    endfunction

    task automatic set_idling(int stage);
        case (stage)
            0:
            begin
                src_idle_pct = 34;
                snk_idle_pct = 49;
            end
            1:
            begin
                src_idle_pct = 49;
                snk_idle_pct = 34;
            end
            default:
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
        endcase
    endtask

    // Offer one beat, hold it until taken, then book its expected status
    task automatic send_event(logic [2:0] f, logic signed [11:0] s, bit fixed, res_t want);
        res_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.func   <= f;
        in_ch.sample <= s;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        r = thermostat_step(f, s);
        pending_status.push_back(fixed ? want : r);
    endtask

    task automatic program_reg(cfg_idx_t idx, int v);
        logic [CFG_DATA_W-1:0] d;
        case (idx)
            CFG_SET_MIN:
            begin
                d = CFG_DATA_W'(v[6:0]);
                cfg_shadow.set_min = v[6:0];
            end
            CFG_SET_MAX:
            begin
                d = CFG_DATA_W'(v[6:0]);
                cfg_shadow.set_max = v[6:0];
            end
            CFG_HYSTERESIS:
            begin
                d = CFG_DATA_W'(v[7:0]);
                cfg_shadow.hysteresis = v[7:0];
            end
            CFG_DEBOUNCE_MS:
            begin
                d = v[13:0];
                cfg_shadow.debounce_ms = v[13:0];
            end
            CFG_BLINK_MS:
            begin
                d = v[13:0];
                cfg_shadow.blink_ms = v[13:0];
            end
            CFG_FAULT_VALUE:
            begin
                d = CFG_DATA_W'(v[11:0]);
                cfg_shadow.fault_value = v[11:0];
            end
            default: d = '0;
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    // Registers only change once every outstanding status has come back
    task automatic apply_settings(int smin, int smax, int hyst, int deb, int blink, int fault);
        while (pending_status.size() != 0)
            @(posedge clk);
        program_reg(CFG_SET_MIN, smin);
        program_reg(CFG_SET_MAX, smax);
        program_reg(CFG_HYSTERESIS, hyst);
        program_reg(CFG_DEBOUNCE_MS, deb);
        program_reg(CFG_BLINK_MS, blink);
        program_reg(CFG_FAULT_VALUE, fault);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [11:0] any_sample();
        int v;
        v = int'($urandom_range(SAMPLE_HI - SAMPLE_LO)) + SAMPLE_LO;
        return v[11:0];
    endfunction

    // Random events, samples biased onto the fault value and the switching band
    task automatic run_random(int count);
        int                 pick;
        int                 hw;
        int                 t;
        logic [2:0]         f;
        logic signed [11:0] s;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 38)
                f = FUNC_TICK;
            else if (pick < 68)
                f = FUNC_SAMPLE;
            else if (pick < 76)
                f = FUNC_PLUS;
            else if (pick < 84)
                f = FUNC_MINUS;
            else if (pick < 96)
                f = FUNC_TOGGLE;
            else
                f = 3'($urandom_range(int'(FUNC_SPARE7), int'(FUNC_SPARE5)));
            s = any_sample();
            if (f == FUNC_SAMPLE)
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                    s = cfg_shadow.fault_value;
                else if (pick < 70)
                begin
                    hw = int'(cfg_shadow.hysteresis) + 24;
                    t  = int'(st_setpoint) * 16 + int'($urandom_range(2 * hw)) - hw;
                    if (t > SAMPLE_HI)
                        t = SAMPLE_HI;
                    if (t < SAMPLE_LO)
                        t = SAMPLE_LO;
                    s = t[11:0];
                end
            end
            send_event(f, s, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, compare each beat with the oldest expectation
    initial
    begin
        res_t want;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_status.size() == 0)
                    flag_mismatch("unexpected beat, mode", out_ch.mode, -1);
                else
                begin
                    want = pending_status.pop_front();
                    if (out_ch.heater_on !== want.heater_on)
                        flag_mismatch("heater_on", out_ch.heater_on, want.heater_on);
                    if (out_ch.red_led !== want.red_led)
                        flag_mismatch("red_led", out_ch.red_led, want.red_led);
                    if (out_ch.green_led !== want.green_led)
                        flag_mismatch("green_led", out_ch.green_led, want.green_led);
                    if (out_ch.mode !== want.mode)
                        flag_mismatch("mode", out_ch.mode, want.mode);
                    if (out_ch.setpoint !== want.setpoint)
                        flag_mismatch("setpoint", out_ch.setpoint, want.setpoint);
                end
            end
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Stimulus
    initial
    begin
        int n;
        mismatches   = 0;
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.func   <= FUNC_TICK;
        in_ch.sample <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_SET_MIN;
        cfg_data     <= '0;

        cfg_shadow.set_min     = 7'd20;
        cfg_shadow.set_max     = 7'd70;
        cfg_shadow.hysteresis  = 8'd8;
        cfg_shadow.debounce_ms = 14'd400;
        cfg_shadow.blink_ms    = 14'd200;
        cfg_shadow.fault_value = 12'sd1360;
        st_mode         = MODE_OFF;
        st_setpoint     = 7'd20;
        st_temp         = '0;
        st_since_toggle = 0;
        st_since_blink  = 0;
        st_red          = 1'b0;
        set_idling(0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at reset settings
        foreach (dir_tab[i])
            send_event(dir_tab[i].func, dir_tab[i].sample, dir_tab[i].fixed, dir_tab[i].want);
        in_ch.valid <= 1'b0;

        // Leave error mode with no debounce
        apply_settings(20, 70, 8, 0, 16383, 500);
        send_event(FUNC_SAMPLE, 12'sd0, 1'b0, '0);
        send_event(FUNC_TICK, 12'sd0, 1'b0, '0);
        send_event(FUNC_TOGGLE, 12'sd0, 1'b0, '0);
        in_ch.valid <= 1'b0;

        // Random phases: fixed corners first, then random settings
        apply_settings(20, 70, 8, 3, 5, 1360);
        run_random(PHASE_BEATS);
        in_ch.valid <= 1'b0;
        apply_settings(0, 127, 0, 0, 1, SAMPLE_LO);
        run_random(PHASE_BEATS);
        in_ch.valid <= 1'b0;
        apply_settings(127, 127, 255, 16382, 16383, SAMPLE_HI);
        run_random(PHASE_BEATS);
        in_ch.valid <= 1'b0;
        set_idling(1);
        apply_settings(100, 30, 20, 2, 3, -1);
        run_random(PHASE_BEATS);
        in_ch.valid <= 1'b0;
        for (int p = 0; p < 4; p++)
        begin
            if (p == 2)
                set_idling(2);
            apply_settings($urandom_range(127), $urandom_range(127), $urandom_range(255),
                           ($urandom_range(9) == 0) ? $urandom_range(16382) : $urandom_range(12),
                           ($urandom_range(9) == 0) ? $urandom_range(16383, 1)
                                                    : $urandom_range(12, 1),
                           int'($urandom_range(SAMPLE_HI - SAMPLE_LO)) + SAMPLE_LO);
            run_random(PHASE_BEATS);
            in_ch.valid <= 1'b0;
        end

        // Drain, then keep watching for stray beats
        for (n = 0; n < 5000 && pending_status.size() != 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_status.size() != 0)
            flag_mismatch("statuses never returned", pending_status.size(), 0);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
